// ----- hdl/rat_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rat_pkg
// Shared types, register indexes, widths and the arctangent table for the
// range/azimuth target locator.
// ---------------------------------------------------------------------------
package rat_pkg;

  localparam int CORDIC_STEPS_DEF = 20;
  localparam int ANGLE_BITS_DEF   = 16;

  // register indexes on the configuration port
  localparam logic [2:0] REG_X_MAP       = 3'd0;
  localparam logic [2:0] REG_Y_MAP       = 3'd1;
  localparam logic [2:0] REG_HEAD_MODE   = 3'd2;
  localparam logic [2:0] REG_FIXED_HEAD  = 3'd3;
  localparam logic [2:0] REG_LOOK_LEFT   = 3'd4;
  localparam logic [2:0] REG_BEAM_OFFSET = 3'd5;
  localparam logic [2:0] REG_GROUND_EN   = 3'd6;

  // axis selector codes
  localparam logic [2:0] AXIS_NONE  = 3'd0;
  localparam logic [2:0] AXIS_EAST  = 3'd1;
  localparam logic [2:0] AXIS_WEST  = 3'd2;
  localparam logic [2:0] AXIS_NORTH = 3'd3;
  localparam logic [2:0] AXIS_SOUTH = 3'd4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // square root: root bits and remainder width
  localparam int SQ_BITS = 35;
  localparam int SQ_W    = 72;
  // vectoring cordic word (velocity scaled by 2^30 plus growth)
  localparam int VEC_W   = 58;
  // rotating cordic word for x, y and residual angle
  localparam int ROT_W   = 34;
  localparam logic signed [ROT_W-1:0] CORDIC_START = 34'sd652032874;
  // east/north sums and final combination
  localparam int E_W     = 39;
  localparam int T_W     = 41;

  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
    32'h00000000, 32'h00000000
  };

  typedef struct packed {
    logic signed [35:0] ref_x;
    logic signed [35:0] ref_y;
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic        [34:0] range_in;
    logic signed [15:0] beam_angle;
    logic signed [19:0] platform_height;
    logic signed [19:0] target_height;
  } rat_in_t;

  typedef struct packed {
    logic signed [35:0] target_x;
    logic signed [35:0] target_y;
    logic signed [19:0] target_z;
    logic               axes_degenerate;
  } rat_out_t;

  // unit coefficient: +1, -1 or 0
  typedef struct packed {
    logic pos;
    logic neg;
  } rat_coef_t;

  // carried through the square root cells
  typedef struct packed {
    logic signed [37:0] ref_e;
    logic signed [37:0] ref_n;
    logic signed [19:0] ht;
    logic        [15:0] theta;
    logic signed [25:0] ve;
    logic signed [25:0] vn;
  } rat_sq_sb_t;

  // carried through the heading cells
  typedef struct packed {
    logic signed [37:0]   ref_e;
    logic signed [37:0]   ref_n;
    logic signed [19:0]   ht;
    logic        [15:0]   theta;
    logic [SQ_BITS-1:0]   g;
    logic                 zero_vel;
  } rat_vec_sb_t;

  // carried through the rotation cells
  typedef struct packed {
    logic signed [37:0]   ref_e;
    logic signed [37:0]   ref_n;
    logic signed [19:0]   ht;
    logic [SQ_BITS-1:0]   g;
    logic                 flip;
  } rat_rot_sb_t;

  function automatic rat_coef_t axis_east(input logic [2:0] sel);
    rat_coef_t c;
    c = '0;
    unique case (sel)
      AXIS_EAST: c.pos = 1'b1;
      AXIS_WEST: c.neg = 1'b1;
      default:   c = '0;
    endcase
    return c;
  endfunction

  function automatic rat_coef_t axis_north(input logic [2:0] sel);
    rat_coef_t c;
    c = '0;
    unique case (sel)
      AXIS_NORTH: c.pos = 1'b1;
      AXIS_SOUTH: c.neg = 1'b1;
      default:    c = '0;
    endcase
    return c;
  endfunction

  function automatic logic signed [2:0] coef_val(input rat_coef_t c);
    logic signed [2:0] v;
    v = c.pos ? 3'sd1 : (c.neg ? -3'sd1 : 3'sd0);
    return v;
  endfunction

  function automatic logic signed [T_W-1:0] apply_coef(input rat_coef_t c,
                                                       input logic signed [T_W-1:0] v);
    logic signed [T_W-1:0] r;
    r = c.pos ? v : (c.neg ? -v : '0);
    return r;
  endfunction

endpackage

// ----- hdl/rat_sqrt_cell.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rat_sqrt_cell
// One bit of a restoring integer square root: tries one root bit against
// the remainder and hands remainder, partial root and sideband on.
// ---------------------------------------------------------------------------
module rat_sqrt_cell #(
  parameter int BIT  = 0,
  parameter int SB_W = 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [rat_pkg::SQ_W-1:0]     in_rem,
  input  logic [rat_pkg::SQ_BITS-1:0]  in_root,
  input  logic [SB_W-1:0]              in_sb,
  output logic                         out_valid,
  output logic [rat_pkg::SQ_W-1:0]     out_rem,
  output logic [rat_pkg::SQ_BITS-1:0]  out_root,
  output logic [SB_W-1:0]              out_sb
);

  logic [rat_pkg::SQ_W-1:0]    trial;
  logic                        fits;
  logic [rat_pkg::SQ_W-1:0]    rem_nxt;
  logic [rat_pkg::SQ_BITS-1:0] root_nxt;
  logic                        valid_r;
  logic [rat_pkg::SQ_W-1:0]    rem_r;
  logic [rat_pkg::SQ_BITS-1:0] root_r;
  logic [SB_W-1:0]             sb_r;

  // (root + 2^b)^2 - root^2
  assign trial = (rat_pkg::SQ_W'(in_root) << (BIT + 1))
               | (rat_pkg::SQ_W'(1) << (2 * BIT));
  assign fits  = in_rem >= trial;

  always_comb begin
    rem_nxt  = fits ? in_rem - trial : in_rem;
    root_nxt = fits ? (in_root | (rat_pkg::SQ_BITS'(1) << BIT)) : in_root;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    sb_r   <= in_sb;
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_root  = root_r;
  assign out_sb    = sb_r;

endmodule

// ----- hdl/rat_vec_cell.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rat_vec_cell
// One vectoring cordic micro-rotation: drives y towards zero and
// accumulates the angle turned.
// ---------------------------------------------------------------------------
module rat_vec_cell #(
  parameter int STEP = 0,
  parameter int SB_W = 1
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic signed [rat_pkg::VEC_W-1:0] in_x,
  input  logic signed [rat_pkg::VEC_W-1:0] in_y,
  input  logic        [31:0]               in_ang,
  input  logic        [SB_W-1:0]           in_sb,
  output logic                             out_valid,
  output logic signed [rat_pkg::VEC_W-1:0] out_x,
  output logic signed [rat_pkg::VEC_W-1:0] out_y,
  output logic        [31:0]               out_ang,
  output logic        [SB_W-1:0]           out_sb
);

  localparam logic [31:0] ATAN = rat_pkg::ATAN_TURNS[STEP];

  logic signed [rat_pkg::VEC_W-1:0] xs, ys, x_nxt, y_nxt;
  logic signed [rat_pkg::VEC_W-1:0] x_r, y_r;
  logic        [31:0]               ang_nxt, ang_r;
  logic                             up;
  logic                             valid_r;
  logic        [SB_W-1:0]           sb_r;

  always_comb begin
    xs      = in_x >>> STEP;
    ys      = in_y >>> STEP;
    up      = in_y > 0;
    x_nxt   = up ? in_x + ys : in_x - ys;
    y_nxt   = up ? in_y - xs : in_y + xs;
    ang_nxt = up ? in_ang + ATAN : in_ang - ATAN;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    ang_r <= ang_nxt;
    sb_r  <= in_sb;
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_ang   = ang_r;
  assign out_sb    = sb_r;

endmodule

// ----- hdl/rat_rot_cell.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rat_rot_cell
// One rotating cordic micro-rotation: turns (x, y) towards the residual
// angle and reduces it by the step's arctangent.
// ---------------------------------------------------------------------------
module rat_rot_cell #(
  parameter int STEP = 0,
  parameter int SB_W = 1
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic signed [rat_pkg::ROT_W-1:0] in_x,
  input  logic signed [rat_pkg::ROT_W-1:0] in_y,
  input  logic signed [rat_pkg::ROT_W-1:0] in_z,
  input  logic        [SB_W-1:0]           in_sb,
  output logic                             out_valid,
  output logic signed [rat_pkg::ROT_W-1:0] out_x,
  output logic signed [rat_pkg::ROT_W-1:0] out_y,
  output logic signed [rat_pkg::ROT_W-1:0] out_z,
  output logic        [SB_W-1:0]           out_sb
);

  localparam logic signed [rat_pkg::ROT_W-1:0] ATAN_Z =
    rat_pkg::ROT_W'(rat_pkg::ATAN_TURNS[STEP]);

  logic signed [rat_pkg::ROT_W-1:0] xs, ys, x_nxt, y_nxt, z_nxt;
  logic signed [rat_pkg::ROT_W-1:0] x_r, y_r, z_r;
  logic                             pos;
  logic                             valid_r;
  logic        [SB_W-1:0]           sb_r;

  always_comb begin
    xs    = in_x >>> STEP;
    ys    = in_y >>> STEP;
    pos   = in_z >= 0;
    x_nxt = pos ? in_x - ys : in_x + ys;
    y_nxt = pos ? in_y + xs : in_y - xs;
    z_nxt = pos ? in_z - ATAN_Z : in_z + ATAN_Z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    x_r  <= x_nxt;
    y_r  <= y_nxt;
    z_r  <= z_nxt;
    sb_r <= in_sb;
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_z     = z_r;
  assign out_sb    = sb_r;

endmodule

// ----- hdl/range_azimuth_target_locator_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// range_azimuth_target_locator_unit
// Places a detection on the ground from platform position, velocity, range
// and beam angle, and maps it back to the local axes.
// ---------------------------------------------------------------------------
// A new transaction is taken on every clock (busy stays low) and its result
// appears on out_data with a one-cycle out_valid strobe, in order, after
// passing through the chain of cells: 35 square-root cells, CORDIC_STEPS
// heading cells and CORDIC_STEPS cos/sin cells, plus eight registered
// stages for the input products, the azimuth sum and the final scaling. The
// receiver cannot stall the output. Configuration writes take effect at once
// and must only be made while no transaction is in flight.
module range_azimuth_target_locator_unit #(
  parameter int CORDIC_STEPS = rat_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_BITS   = rat_pkg::ANGLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  rat_pkg::rat_in_t                  in_data,
  output logic                              out_valid,
  output rat_pkg::rat_out_t                 out_data,
  input  logic                              cfg_we,
  input  logic [rat_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rat_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int SQ_BITS = rat_pkg::SQ_BITS;
  localparam int SQ_W    = rat_pkg::SQ_W;
  localparam int VEC_W   = rat_pkg::VEC_W;
  localparam int ROT_W   = rat_pkg::ROT_W;
  localparam int E_W     = rat_pkg::E_W;
  localparam int T_W     = rat_pkg::T_W;
  localparam logic [31:0] AZ_HALF = 32'd1 << (31 - ANGLE_BITS);
  localparam logic [31:0] AZ_MASK = (32'd1 << (32 - ANGLE_BITS)) - 32'd1;
  localparam logic signed [T_W-1:0] SAT_MAX = T_W'(36'sh7_FFFF_FFFF);
  localparam logic signed [T_W-1:0] SAT_MIN = -T_W'(37'sh8_0000_0000);

  // ---------------- configuration registers ----------------
  logic [2:0]  x_map_r, y_map_r;
  logic        head_mode_r, look_left_r, ground_en_r;
  logic [15:0] fixed_head_r, beam_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_map_r       <= rat_pkg::AXIS_EAST;
      y_map_r       <= rat_pkg::AXIS_NORTH;
      head_mode_r   <= 1'b0;
      fixed_head_r  <= '0;
      look_left_r   <= 1'b0;
      beam_offset_r <= '0;
      ground_en_r   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rat_pkg::REG_X_MAP:       x_map_r       <= cfg_wdata[2:0];
        rat_pkg::REG_Y_MAP:       y_map_r       <= cfg_wdata[2:0];
        rat_pkg::REG_HEAD_MODE:   head_mode_r   <= cfg_wdata[0];
        rat_pkg::REG_FIXED_HEAD:  fixed_head_r  <= cfg_wdata;
        rat_pkg::REG_LOOK_LEFT:   look_left_r   <= cfg_wdata[0];
        rat_pkg::REG_BEAM_OFFSET: beam_offset_r <= cfg_wdata;
        rat_pkg::REG_GROUND_EN:   ground_en_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  rat_pkg::rat_coef_t xe, xn, ye, yn, det_c;
  logic signed [2:0]  det;

  always_comb begin
    xe    = rat_pkg::axis_east(x_map_r);
    xn    = rat_pkg::axis_north(x_map_r);
    ye    = rat_pkg::axis_east(y_map_r);
    yn    = rat_pkg::axis_north(y_map_r);
    det   = 3'(rat_pkg::coef_val(xe) * rat_pkg::coef_val(yn))
          - 3'(rat_pkg::coef_val(ye) * rat_pkg::coef_val(xn));
    det_c.pos = det > 0;
    det_c.neg = det < 0;
  end

  assign busy = 1'b0;

  // ---------------- stage 1: axis mapping and input products ----------------
  rat_pkg::rat_sq_sb_t s1_sb_nxt, s1_sb_r;
  logic signed [20:0]  dz;
  logic        [20:0]  dabs;
  logic        [41:0]  d2_nxt, s1_d2_r;
  logic        [33:0]  s1_hh_r;
  logic        [34:0]  s1_hl_r;
  logic        [35:0]  s1_ll_r;
  logic                s1_v_r;

  always_comb begin
    s1_sb_nxt.ref_e = 38'(rat_pkg::apply_coef(xe, T_W'(in_data.ref_x))
                        + rat_pkg::apply_coef(ye, T_W'(in_data.ref_y)));
    s1_sb_nxt.ref_n = 38'(rat_pkg::apply_coef(xn, T_W'(in_data.ref_x))
                        + rat_pkg::apply_coef(yn, T_W'(in_data.ref_y)));
    s1_sb_nxt.ve    = 26'(rat_pkg::apply_coef(xe, T_W'(in_data.vel_x))
                        + rat_pkg::apply_coef(ye, T_W'(in_data.vel_y)));
    s1_sb_nxt.vn    = 26'(rat_pkg::apply_coef(xn, T_W'(in_data.vel_x))
                        + rat_pkg::apply_coef(yn, T_W'(in_data.vel_y)));
    s1_sb_nxt.ht    = in_data.target_height;
    s1_sb_nxt.theta = in_data.beam_angle;
    dz     = 21'(in_data.platform_height) - 21'(in_data.target_height);
    dabs   = dz[20] ? 21'(-dz) : 21'(dz);
    // with ground range off the root of range squared gives the range back
    d2_nxt = ground_en_r ? 42'(dabs * dabs) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= start & ~busy;
    end
    s1_sb_r <= s1_sb_nxt;
    s1_d2_r <= d2_nxt;
    s1_hh_r <= in_data.range_in[34:18] * in_data.range_in[34:18];
    s1_hl_r <= 35'(in_data.range_in[34:18] * in_data.range_in[17:0]);
    s1_ll_r <= in_data.range_in[17:0] * in_data.range_in[17:0];
  end

  // ---------------- stage 2: range squared ----------------
  rat_pkg::rat_sq_sb_t s2_sb_r;
  logic [69:0] s2_r2_r;
  logic [41:0] s2_d2_r;
  logic        s2_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
    s2_sb_r <= s1_sb_r;
    s2_d2_r <= s1_d2_r;
    s2_r2_r <= (70'(s1_hh_r) << 36) + (70'(s1_hl_r) << 19) + 70'(s1_ll_r);
  end

  // ---------------- stage 3: radicand ----------------
  rat_pkg::rat_sq_sb_t s3_sb_r;
  logic [SQ_W-1:0]     s3_n_r;
  logic                s3_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= s2_v_r;
    end
    s3_sb_r <= s2_sb_r;
    // height difference at or above range gives zero ground range
    s3_n_r  <= (s2_r2_r > 70'(s2_d2_r)) ? SQ_W'(s2_r2_r - 70'(s2_d2_r)) : '0;
  end

  // ---------------- square root chain ----------------
  logic                sq_v    [0:SQ_BITS];
  logic [SQ_W-1:0]     sq_rem  [0:SQ_BITS];
  logic [SQ_BITS-1:0]  sq_root [0:SQ_BITS];
  rat_pkg::rat_sq_sb_t sq_sb   [0:SQ_BITS];

  assign sq_v[0]    = s3_v_r;
  assign sq_rem[0]  = s3_n_r;
  assign sq_root[0] = '0;
  assign sq_sb[0]   = s3_sb_r;

  for (genvar k = 0; k < SQ_BITS; k++) begin : g_sqrt
    rat_sqrt_cell #(
      .BIT  (SQ_BITS - 1 - k),
      .SB_W ($bits(rat_pkg::rat_sq_sb_t))
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (sq_v[k]),
      .in_rem    (sq_rem[k]),
      .in_root   (sq_root[k]),
      .in_sb     (sq_sb[k]),
      .out_valid (sq_v[k+1]),
      .out_rem   (sq_rem[k+1]),
      .out_root  (sq_root[k+1]),
      .out_sb    (sq_sb[k+1])
    );
  end

  // ---------------- heading chain ----------------
  logic                      vec_v   [0:CORDIC_STEPS];
  logic signed [VEC_W-1:0]   vec_x   [0:CORDIC_STEPS];
  logic signed [VEC_W-1:0]   vec_y   [0:CORDIC_STEPS];
  logic        [31:0]        vec_ang [0:CORDIC_STEPS];
  rat_pkg::rat_vec_sb_t      vec_sb  [0:CORDIC_STEPS];
  rat_pkg::rat_sq_sb_t       sq_end;
  logic signed [25:0]        vef, vnf;
  logic                      ve_neg;

  always_comb begin
    sq_end = sq_sb[SQ_BITS];
    ve_neg = sq_end.ve < 0;
    // left half plane turned by half a turn first
    vef    = ve_neg ? -sq_end.ve : sq_end.ve;
    vnf    = ve_neg ? -sq_end.vn : sq_end.vn;
    vec_v[0]   = sq_v[SQ_BITS];
    vec_x[0]   = {{2{vef[25]}}, vef, 30'd0};
    vec_y[0]   = {{2{vnf[25]}}, vnf, 30'd0};
    vec_ang[0] = ve_neg ? 32'h8000_0000 : 32'h0000_0000;
    vec_sb[0].ref_e    = sq_end.ref_e;
    vec_sb[0].ref_n    = sq_end.ref_n;
    vec_sb[0].ht       = sq_end.ht;
    vec_sb[0].theta    = sq_end.theta;
    vec_sb[0].g        = sq_root[SQ_BITS];
    vec_sb[0].zero_vel = (sq_end.ve == 0) && (sq_end.vn == 0);
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vec
    rat_vec_cell #(
      .STEP (k),
      .SB_W ($bits(rat_pkg::rat_vec_sb_t))
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (vec_v[k]),
      .in_x      (vec_x[k]),
      .in_y      (vec_y[k]),
      .in_ang    (vec_ang[k]),
      .in_sb     (vec_sb[k]),
      .out_valid (vec_v[k+1]),
      .out_x     (vec_x[k+1]),
      .out_y     (vec_y[k+1]),
      .out_ang   (vec_ang[k+1]),
      .out_sb    (vec_sb[k+1])
    );
  end

  // ---------------- azimuth stage ----------------
  rat_pkg::rat_vec_sb_t vec_end;
  rat_pkg::rat_rot_sb_t az_sb_nxt, az_sb_r;
  logic [31:0]          head, side, az_raw, az;
  logic                 flip;
  logic signed [ROT_W-1:0] az_z_nxt, az_z_r;
  logic                 az_v_r;

  always_comb begin
    vec_end = vec_sb[CORDIC_STEPS];
    head    = head_mode_r      ? {fixed_head_r, 16'd0}
            : vec_end.zero_vel ? 32'd0 : vec_ang[CORDIC_STEPS];
    side    = look_left_r ? 32'h4000_0000 : 32'hC000_0000;
    az_raw  = head + side + {vec_end.theta, 16'd0} + {beam_offset_r, 16'd0};
    az      = (az_raw + AZ_HALF) & ~AZ_MASK;
    // fold the back half into +-90 degrees
    flip    = az[31] ^ az[30];
    az_z_nxt = ROT_W'($signed({az[31] ^ flip, az[30:0]}));
    az_sb_nxt.ref_e = vec_end.ref_e;
    az_sb_nxt.ref_n = vec_end.ref_n;
    az_sb_nxt.ht    = vec_end.ht;
    az_sb_nxt.g     = vec_end.g;
    az_sb_nxt.flip  = flip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      az_v_r <= 1'b0;
    end else begin
      az_v_r <= vec_v[CORDIC_STEPS];
    end
    az_z_r  <= az_z_nxt;
    az_sb_r <= az_sb_nxt;
  end

  // ---------------- cos/sin chain ----------------
  logic                    rot_v  [0:CORDIC_STEPS];
  logic signed [ROT_W-1:0] rot_x  [0:CORDIC_STEPS];
  logic signed [ROT_W-1:0] rot_y  [0:CORDIC_STEPS];
  logic signed [ROT_W-1:0] rot_z  [0:CORDIC_STEPS];
  rat_pkg::rat_rot_sb_t    rot_sb [0:CORDIC_STEPS];

  assign rot_v[0]  = az_v_r;
  assign rot_x[0]  = rat_pkg::CORDIC_START;
  assign rot_y[0]  = '0;
  assign rot_z[0]  = az_z_r;
  assign rot_sb[0] = az_sb_r;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
    rat_rot_cell #(
      .STEP (k),
      .SB_W ($bits(rat_pkg::rat_rot_sb_t))
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (rot_v[k]),
      .in_x      (rot_x[k]),
      .in_y      (rot_y[k]),
      .in_z      (rot_z[k]),
      .in_sb     (rot_sb[k]),
      .out_valid (rot_v[k+1]),
      .out_x     (rot_x[k+1]),
      .out_y     (rot_y[k+1]),
      .out_z     (rot_z[k+1]),
      .out_sb    (rot_sb[k+1])
    );
  end

  // rot_z at the end of the chain is the leftover angle, not needed
  logic signed [ROT_W-1:0] z_left;
  assign z_left = rot_z[CORDIC_STEPS];

  // ---------------- scaling: partial products ----------------
  rat_pkg::rat_rot_sb_t    rot_end;
  logic signed [ROT_W-1:0] cv, sv;
  logic        [30:0]      cmag, smag;
  logic                    p1_v_r, p1_cneg_r, p1_sneg_r;
  logic        [47:0]      p1_ch_r, p1_sh_r;
  logic        [48:0]      p1_cl_r, p1_sl_r;
  logic signed [37:0]      p1_ref_e_r, p1_ref_n_r;
  logic signed [19:0]      p1_ht_r;

  always_comb begin
    rot_end = rot_sb[CORDIC_STEPS];
    cv      = rot_end.flip ? -rot_x[CORDIC_STEPS] : rot_x[CORDIC_STEPS];
    sv      = rot_end.flip ? -rot_y[CORDIC_STEPS] : rot_y[CORDIC_STEPS];
    cmag    = cv[ROT_W-1] ? 31'(-cv) : 31'(cv);
    smag    = sv[ROT_W-1] ? 31'(-sv) : 31'(sv);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else begin
      p1_v_r <= rot_v[CORDIC_STEPS] & (z_left == z_left);
    end
    p1_cneg_r  <= cv[ROT_W-1];
    p1_sneg_r  <= sv[ROT_W-1];
    p1_ch_r    <= rot_end.g[34:18] * cmag;
    p1_cl_r    <= rot_end.g[17:0] * cmag;
    p1_sh_r    <= rot_end.g[34:18] * smag;
    p1_sl_r    <= rot_end.g[17:0] * smag;
    p1_ref_e_r <= rot_end.ref_e;
    p1_ref_n_r <= rot_end.ref_n;
    p1_ht_r    <= rot_end.ht;
  end

  // ---------------- scaling: sum and round ----------------
  logic [65:0]        prod_c, prod_s;
  logic [65:0]        rnd_c, rnd_s;
  logic               p2_v_r, p2_cneg_r, p2_sneg_r;
  logic [35:0]        p2_rc_r, p2_rs_r;
  logic signed [37:0] p2_ref_e_r, p2_ref_n_r;
  logic signed [19:0] p2_ht_r;

  always_comb begin
    prod_c = (66'(p1_ch_r) << 18) + 66'(p1_cl_r);
    prod_s = (66'(p1_sh_r) << 18) + 66'(p1_sl_r);
    // round to nearest, halves away from zero on the magnitude
    rnd_c  = prod_c + (66'd1 << 29);
    rnd_s  = prod_s + (66'd1 << 29);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else begin
      p2_v_r <= p1_v_r;
    end
    p2_cneg_r  <= p1_cneg_r;
    p2_sneg_r  <= p1_sneg_r;
    p2_rc_r    <= rnd_c[65:30];
    p2_rs_r    <= rnd_s[65:30];
    p2_ref_e_r <= p1_ref_e_r;
    p2_ref_n_r <= p1_ref_n_r;
    p2_ht_r    <= p1_ht_r;
  end

  // ---------------- east/north position ----------------
  logic signed [E_W-1:0] off_e, off_n;
  logic signed [E_W-1:0] p3_e_r, p3_n_r;
  logic signed [19:0]    p3_ht_r;
  logic                  p3_v_r;

  always_comb begin
    off_e = p2_cneg_r ? -E_W'({1'b0, p2_rc_r}) : E_W'({1'b0, p2_rc_r});
    off_n = p2_sneg_r ? -E_W'({1'b0, p2_rs_r}) : E_W'({1'b0, p2_rs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_v_r <= 1'b0;
    end else begin
      p3_v_r <= p2_v_r;
    end
    p3_e_r  <= E_W'(p2_ref_e_r) + off_e;
    p3_n_r  <= E_W'(p2_ref_n_r) + off_n;
    p3_ht_r <= p2_ht_r;
  end

  // ---------------- back to local axes, saturate ----------------
  logic signed [T_W-1:0] ax, ay, tx, ty;
  rat_pkg::rat_out_t     out_nxt, out_r;
  logic                  out_v_r;

  always_comb begin
    ax = rat_pkg::apply_coef(yn, T_W'(p3_e_r)) - rat_pkg::apply_coef(ye, T_W'(p3_n_r));
    ay = rat_pkg::apply_coef(xe, T_W'(p3_n_r)) - rat_pkg::apply_coef(xn, T_W'(p3_e_r));
    tx = rat_pkg::apply_coef(det_c, ax);
    ty = rat_pkg::apply_coef(det_c, ay);
    out_nxt.target_x = (tx > SAT_MAX) ? 36'(SAT_MAX) : (tx < SAT_MIN) ? 36'(SAT_MIN) : 36'(tx);
    out_nxt.target_y = (ty > SAT_MAX) ? 36'(SAT_MAX) : (ty < SAT_MIN) ? 36'(SAT_MIN) : 36'(ty);
    out_nxt.target_z = p3_ht_r;
    out_nxt.axes_degenerate = (det == 0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= p3_v_r;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule
